### rtl/multi_voice_sample_mixer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-voice sample mixer
// Shared forms for the concurrent checks of the mixer modules.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH
`define MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MVSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MVSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// Mixer package
// Sizes, codes and constants shared by the mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package mvsm_pkg;
  localparam int NUM_SOUNDS = 8;
  localparam int MAX_FRAMES = 4096;
  localparam int MAX_VOICES = 16;

  localparam int SID_W   = 3;
  localparam int POS_W   = 12;
  localparam int LEN_W   = 13;
  localparam int PHASE_W = 29;
  localparam int STEP_W  = 22;
  localparam int VIDX_W  = 4;
  localparam int VCNT_W  = 5;

  localparam int DVD_W = 34;
  localparam int DVS_W = 17;
  localparam int DCNT_W = 6;

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam logic [16:0] SCALE_DIV = 17'd65025;
  localparam logic [16:0] SCALE_RECIP = 17'd66051;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAMES);
  localparam logic [16:0] OUT_RATE_RESET = 17'd44100;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_DEFINE = 2'd1;
  localparam logic [1:0] OP_PLAY   = 2'd2;
  localparam logic [1:0] OP_RENDER = 2'd3;
endpackage
`default_nettype wire

### rtl/multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// Multi-voice sample mixer
// Stereo sample playback with per-voice volume and pan, mixed to 16 bits.
// ----------------------------------------------------------------------------
// Each input transaction gives exactly one output transaction. A frame write
// or a play request goes from acceptance straight to the finish state. A
// sound definition waits for the bit-serial divider that works out the phase
// step. A render walks every voice in the table; every voice that still
// plays needs one sample store read and then four passes of the single
// shared multiplier per channel (gain, product, reciprocal estimate,
// remainder check), followed by a phase update. A voice that has already run
// out only takes the store read, the gain state and the phase update. The
// block takes no new transaction while one is being worked on; a finished
// result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_voice_sample_mixer_macros.svh"
module multi_voice_sample_mixer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [16:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [2:0]         sound_id,
  input  wire logic [11:0]        frame_index,
  input  wire logic signed [15:0] left_in,
  input  wire logic signed [15:0] right_in,
  input  wire logic [12:0]        length,
  input  wire logic [17:0]        rate,
  input  wire logic [7:0]         volume,
  input  wire logic [7:0]         pan,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_left,
  output logic signed [15:0]      out_right,
  output logic                    status
);
  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_VRD  = 4'd2;
  localparam logic [3:0] ST_GAIN = 4'd3;
  localparam logic [3:0] ST_MAG  = 4'd4;
  localparam logic [3:0] ST_QEST = 4'd5;
  localparam logic [3:0] ST_QFIX = 4'd6;
  localparam logic [3:0] ST_VUPD = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state;
  logic       accept;

  logic [16:0] out_rate;

  // Sample store: left in the low half, right in the high half.
  logic [31:0] sample_store [mvsm_pkg::NUM_SOUNDS * mvsm_pkg::MAX_FRAMES];
  logic [31:0] smp;

  logic [mvsm_pkg::LEN_W-1:0]  slot_length [mvsm_pkg::NUM_SOUNDS];
  logic [mvsm_pkg::STEP_W-1:0] slot_step   [mvsm_pkg::NUM_SOUNDS];

  // Voice table, kept in age order, compacted during each render.
  logic [mvsm_pkg::SID_W-1:0]   v_slot  [mvsm_pkg::MAX_VOICES];
  logic [mvsm_pkg::PHASE_W-1:0] v_phase [mvsm_pkg::MAX_VOICES];
  logic [7:0]                   v_vol   [mvsm_pkg::MAX_VOICES];
  logic [7:0]                   v_pan   [mvsm_pkg::MAX_VOICES];
  logic [mvsm_pkg::VCNT_W-1:0]  voice_count;

  logic [mvsm_pkg::VIDX_W-1:0] vidx;
  logic [mvsm_pkg::VCNT_W-1:0] kept;
  logic                        act;
  logic                        ch;
  logic [15:0]                 gain;
  logic [30:0]                 mag;
  logic                        neg;
  logic [15:0]                 qest;
  logic signed [15:0]          acc_l;
  logic signed [15:0]          acc_r;
  logic                        res_status;

  // Latched fields of a sound definition while the divider runs.
  logic [mvsm_pkg::SID_W-1:0] def_sid;

  logic                        div_start;
  logic                        div_done;
  logic [mvsm_pkg::DVD_W-1:0]  div_q;

  // Current voice, read at the walking index.
  logic [mvsm_pkg::SID_W-1:0]   cur_slot;
  logic [mvsm_pkg::PHASE_W-1:0] cur_phase;
  logic [mvsm_pkg::LEN_W-1:0]   cur_len;
  logic [mvsm_pkg::LEN_W-1:0]   cur_pos;
  logic [mvsm_pkg::PHASE_W-1:0] new_phase;
  logic                         keep;
  logic                         last_voice;

  logic signed [15:0] cur_smp;
  logic [15:0]        smp_abs;

  // The one shared multiplier and its operand selection.
  logic [30:0] mul_a;
  logic [16:0] mul_b;
  logic [47:0] prod;

  logic [30:0]        rem;
  logic [15:0]        qfix;
  logic signed [17:0] contrib;
  logic signed [17:0] sum;
  logic signed [15:0] sum_sat;

  logic [mvsm_pkg::STEP_W-1:0] step_val;
  logic [mvsm_pkg::LEN_W-1:0]  len_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != ST_IDLE;

  assign cur_slot   = v_slot[vidx];
  assign cur_phase  = v_phase[vidx];
  assign cur_len    = slot_length[cur_slot];
  assign cur_pos    = cur_phase[mvsm_pkg::PHASE_W-1:16];
  assign new_phase  = act ? cur_phase + mvsm_pkg::PHASE_W'(slot_step[cur_slot]) : cur_phase;
  assign keep       = new_phase[mvsm_pkg::PHASE_W-1:16] < cur_len;
  assign last_voice = ({1'b0, vidx} + 1'b1) == voice_count;

  assign cur_smp = ch ? signed'(smp[31:16]) : signed'(smp[15:0]);
  assign smp_abs = cur_smp[15] ? 16'(-cur_smp) : 16'(cur_smp);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_GAIN: begin
        mul_a = 31'(v_vol[vidx]);
        mul_b = ch ? 17'(v_pan[vidx]) : 17'(8'd255 - v_pan[vidx]);
      end
      ST_MAG: begin
        mul_a = 31'(smp_abs);
        mul_b = 17'(gain);
      end
      ST_QEST: begin
        mul_a = mag;
        mul_b = mvsm_pkg::SCALE_RECIP;
      end
      ST_QFIX: begin
        mul_a = 31'(qest);
        mul_b = mvsm_pkg::SCALE_DIV;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 48'(mul_a) * 48'(mul_b);

  // The reciprocal estimate is the true quotient or one less; one compare
  // on the remainder settles which.
  assign rem     = mag - prod[30:0];
  assign qfix    = qest + 16'(rem >= 31'(mvsm_pkg::SCALE_DIV));
  assign contrib = neg ? -signed'({2'b00, qfix}) : signed'({2'b00, qfix});
  assign sum     = 18'(ch ? acc_r : acc_l) + contrib;

  always_comb begin
    priority if (sum > 18'sd32767) begin
      sum_sat = 16'sd32767;
    end else if (sum < -18'sd32768) begin
      sum_sat = -16'sd32768;
    end else begin
      sum_sat = sum[15:0];
    end
  end

  // Step saturates on overflow and on a zero output rate.
  assign step_val = (out_rate == '0 || div_q[mvsm_pkg::DVD_W-1:mvsm_pkg::STEP_W] != '0) ?
                    mvsm_pkg::STEP_MAX : div_q[mvsm_pkg::STEP_W-1:0];
  assign len_sat  = (length > mvsm_pkg::LEN_MAX) ? mvsm_pkg::LEN_MAX : length;

  assign div_start = accept && op == mvsm_pkg::OP_DEFINE;

  mvsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({rate, 16'h0000}),
    .divisor  (out_rate),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sample store ports.
  always_ff @(posedge clk) begin
    if (accept && op == mvsm_pkg::OP_WRITE) begin
      sample_store[{sound_id, frame_index}] <= {right_in, left_in};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_VRD) begin
      smp <= sample_store[{cur_slot, cur_pos[mvsm_pkg::POS_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rate <= mvsm_pkg::OUT_RATE_RESET;
    end else if (cfg_we) begin
      out_rate <= cfg_wdata;
    end
  end

  // Slot tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < mvsm_pkg::NUM_SOUNDS; k++) begin
        slot_length[k] <= '0;
        slot_step[k]   <= '0;
      end
    end else begin
      if (accept && op == mvsm_pkg::OP_DEFINE) begin
        slot_length[sound_id] <= len_sat;
      end
      if (state == ST_DIV && div_done) begin
        slot_step[def_sid] <= step_val;
      end
    end
  end

  // Voice table payload: new voices append, the render compacts in place.
  always_ff @(posedge clk) begin
    if (accept && op == mvsm_pkg::OP_PLAY &&
        voice_count < mvsm_pkg::VCNT_W'(mvsm_pkg::MAX_VOICES)) begin
      v_slot[voice_count[mvsm_pkg::VIDX_W-1:0]]  <= sound_id;
      v_phase[voice_count[mvsm_pkg::VIDX_W-1:0]] <= '0;
      v_vol[voice_count[mvsm_pkg::VIDX_W-1:0]]   <= volume;
      v_pan[voice_count[mvsm_pkg::VIDX_W-1:0]]   <= pan;
    end else if (state == ST_VUPD && keep) begin
      v_slot[kept[mvsm_pkg::VIDX_W-1:0]]  <= cur_slot;
      v_phase[kept[mvsm_pkg::VIDX_W-1:0]] <= new_phase;
      v_vol[kept[mvsm_pkg::VIDX_W-1:0]]   <= v_vol[vidx];
      v_pan[kept[mvsm_pkg::VIDX_W-1:0]]   <= v_pan[vidx];
    end
  end

  // Datapath registers of the render walk.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_VRD:  act  <= cur_pos < cur_len;
      ST_GAIN: gain <= prod[15:0];
      ST_MAG: begin
        mag <= prod[30:0];
        neg <= cur_smp[15];
      end
      ST_QEST: qest <= prod[47:32];
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      voice_count <= '0;
      vidx        <= '0;
      kept        <= '0;
      ch          <= 1'b0;
      acc_l       <= '0;
      acc_r       <= '0;
      res_status  <= 1'b0;
      def_sid     <= '0;
      out_valid   <= 1'b0;
      out_left    <= '0;
      out_right   <= '0;
      status      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            acc_l      <= '0;
            acc_r      <= '0;
            res_status <= 1'b0;
            vidx       <= '0;
            kept       <= '0;
            ch         <= 1'b0;
            unique case (op)
              mvsm_pkg::OP_WRITE: state <= ST_FIN;
              mvsm_pkg::OP_DEFINE: begin
                def_sid <= sound_id;
                state   <= ST_DIV;
              end
              mvsm_pkg::OP_PLAY: begin
                if (voice_count < mvsm_pkg::VCNT_W'(mvsm_pkg::MAX_VOICES)) begin
                  voice_count <= voice_count + 1'b1;
                end else begin
                  res_status <= 1'b1;
                end
                state <= ST_FIN;
              end
              mvsm_pkg::OP_RENDER: state <= (voice_count == '0) ? ST_FIN : ST_VRD;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_VRD: state <= ST_GAIN;
        ST_GAIN: begin
          state <= act ? ST_MAG : ST_VUPD;
        end
        ST_MAG:  state <= ST_QEST;
        ST_QEST: state <= ST_QFIX;
        ST_QFIX: begin
          if (ch) begin
            acc_r <= sum_sat;
            ch    <= 1'b0;
            state <= ST_VUPD;
          end else begin
            acc_l <= sum_sat;
            ch    <= 1'b1;
            state <= ST_GAIN;
          end
        end
        ST_VUPD: begin
          vidx <= vidx + 1'b1;
          if (keep) begin
            kept <= kept + 1'b1;
          end
          if (last_voice) begin
            voice_count <= kept + mvsm_pkg::VCNT_W'(keep);
            state       <= ST_FIN;
          end else begin
            state <= ST_VRD;
          end
        end
        ST_FIN: begin
          // A result still waiting is not overwritten.
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_left  <= acc_l;
            out_right <= acc_r;
            status    <= res_status;
            state     <= ST_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MVSM_ASSERT_NOW(a_count_bound, 1'b1, voice_count <= mvsm_pkg::VCNT_W'(mvsm_pkg::MAX_VOICES), "voice count beyond table size")
  `MVSM_ASSERT_NOW(a_kept_order, state == ST_VUPD, kept <= {1'b0, vidx}, "compaction overtook the walk")
  `MVSM_ASSERT_NEXT(a_result_source, !out_valid && state != ST_FIN, !out_valid, "result without a finished transaction")
  `MVSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_left) && $stable(out_right) && $stable(status), "stalled output changed")
endmodule
`default_nettype wire

### rtl/mvsm_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mvsm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mvsm_pkg::DVD_W-1:0]    dividend,
  input  wire logic [mvsm_pkg::DVS_W-1:0]    divisor,
  output logic                               done,
  output logic [mvsm_pkg::DVD_W-1:0]         quotient
);
  logic                        busy;
  logic [mvsm_pkg::DCNT_W-1:0] cnt;
  logic [mvsm_pkg::DVS_W-1:0]  rem;
  logic [mvsm_pkg::DVS_W-1:0]  dvs;
  logic [mvsm_pkg::DVS_W:0]    trial;
  logic                        fits;
  logic                        last_bit;

  assign trial    = {rem, quotient[mvsm_pkg::DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign last_bit = cnt == mvsm_pkg::DCNT_W'(mvsm_pkg::DVD_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && last_bit;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? mvsm_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[mvsm_pkg::DVS_W-1:0];
      quotient <= {quotient[mvsm_pkg::DVD_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

### tb/sv/tb_multi_voice_sample_mixer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the multi-voice sample mixer
// Drives frame writes, sound definitions, play requests and renders through
// the valid/stall input channel. A behavioural copy of the mixer predicts each
// output transaction, and every output is compared in order against it.
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;

  // Generous ceiling on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         sid;
    logic [11:0]        fidx;
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic [12:0]        len;
    logic [17:0]        rate;
    logic [7:0]         vol;
    logic [7:0]         pan;
  } mix_cmd_t;

  typedef struct {
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic               st;
  } mix_out_t;

  typedef struct {
    logic [2:0]  slot;
    logic [31:0] phase;
    logic [7:0]  vol;
    logic [7:0]  pan;
  } voice_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [2:0] sound_id = '0;
  logic [11:0] frame_index = '0;
  logic signed [15:0] left_in = '0;
  logic signed [15:0] right_in = '0;
  logic [12:0] length = '0;
  logic [17:0] rate = '0;
  logic [7:0] volume = '0;
  logic [7:0] pan = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic status;

  // Copy of the mixer state kept by the testbench.
  logic [31:0] pcm_store [mvsm_pkg::NUM_SOUNDS][mvsm_pkg::MAX_FRAMES];
  bit          pcm_written [mvsm_pkg::NUM_SOUNDS][mvsm_pkg::MAX_FRAMES];
  logic [12:0] slot_len [mvsm_pkg::NUM_SOUNDS];
  logic [21:0] slot_step [mvsm_pkg::NUM_SOUNDS];
  voice_t      voices [mvsm_pkg::MAX_VOICES];
  int          voice_cnt;
  logic [16:0] rate_reg;

  mix_out_t expected_mix [$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       offering = 0;   // in_valid currently scheduled high
  bit       quiet = 0;      // no random idling on either side
  bit       long_hold = 0;  // ask the receiver for a long hold-off

  always #5 clk = ~clk;

  multi_voice_sample_mixer DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .sound_id(sound_id),
    .frame_index(frame_index), .left_in(left_in), .right_in(right_in),
    .length(length), .rate(rate), .volume(volume), .pan(pan),
    .out_valid(out_valid), .out_stall(out_stall), .out_left(out_left),
    .out_right(out_right), .status(status)
  );

  // The run is abandoned if it has not finished within the limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Works out the output of one accepted transaction and updates the state
  // copy. Every transaction yields exactly one output.
  function automatic void mix_predict(input mix_cmd_t c);
    mix_out_t e;
    int acc_l, acc_r, lg, rg, smp, kept;
    logic [31:0] w;
    logic [15:0] pos;
    longint unsigned st;
    e.st = 1'b0;
    acc_l = 0;
    acc_r = 0;
    case (c.op)
      mvsm_pkg::OP_WRITE: begin
        pcm_store[c.sid][c.fidx] = {c.r, c.l};
        pcm_written[c.sid][c.fidx] = 1;
      end
      mvsm_pkg::OP_DEFINE: begin
        slot_len[c.sid] = (c.len > mvsm_pkg::LEN_MAX) ? mvsm_pkg::LEN_MAX : c.len;
        if (rate_reg == 0) begin
          st = 64'(mvsm_pkg::STEP_MAX);
        end else begin
          st = ({46'd0, c.rate} << 16) / 64'(rate_reg);
          if (st > 64'(mvsm_pkg::STEP_MAX)) st = 64'(mvsm_pkg::STEP_MAX);
        end
        slot_step[c.sid] = st[21:0];
      end
      mvsm_pkg::OP_PLAY: begin
        if (voice_cnt >= mvsm_pkg::MAX_VOICES) begin
          e.st = 1'b1;
        end else begin
          voices[voice_cnt] = '{c.sid, 32'd0, c.vol, c.pan};
          voice_cnt++;
        end
      end
      default: begin
        // Oldest voice first; the running sums saturate after every add.
        for (int i = 0; i < voice_cnt; i++) begin
          pos = voices[i].phase[31:16];
          if (pos < slot_len[voices[i].slot]) begin
            w = pcm_store[voices[i].slot][pos];
            lg = voices[i].vol * (255 - voices[i].pan);
            rg = voices[i].vol * voices[i].pan;
            smp = int'($signed(w[15:0]));
            acc_l = sat16(acc_l + (smp * lg) / 65025);
            smp = int'($signed(w[31:16]));
            acc_r = sat16(acc_r + (smp * rg) / 65025);
            voices[i].phase += 32'(slot_step[voices[i].slot]);
          end
        end
        // Finished voices drop out and the rest close up in order.
        kept = 0;
        for (int i = 0; i < voice_cnt; i++) begin
          if (voices[i].phase[31:16] < 16'(slot_len[voices[i].slot])) begin
            voices[kept] = voices[i];
            kept++;
          end
        end
        voice_cnt = kept;
      end
    endcase
    e.l = acc_l[15:0];
    e.r = acc_r[15:0];
    expected_mix = {expected_mix, e};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // Output checker: each accepted output is compared with the oldest
  // expectation waiting in the queue.
  always @(posedge clk) begin
    mix_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_mix.size() == 0) begin
        report_mismatch("unexpected output, left", out_left, 0);
      end else begin
        e = expected_mix.pop_front();
        if (out_left !== e.l) report_mismatch("out_left", out_left, e.l);
        if (out_right !== e.r) report_mismatch("out_right", out_right, e.r);
        if (status !== e.st) report_mismatch("status", status, e.st);
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when one is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Lowers the input valid, at most once in any time step.
  task automatic drop_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 0;
    end
  endtask

  // Sends one transaction and returns in the time step of its acceptance,
  // leaving valid high so that a following transaction can go back to back.
  task automatic send_item(input mix_cmd_t c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    mix_predict(c);
    op <= c.op;
    sound_id <= c.sid;
    frame_index <= c.fidx;
    left_in <= c.l;
    right_in <= c.r;
    length <= c.len;
    rate <= c.rate;
    volume <= c.vol;
    pan <= c.pan;
    in_valid <= 1'b1;
    offering = 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_write(input int s, input int f, input int l, input int r);
    mix_cmd_t c;
    c = '{mvsm_pkg::OP_WRITE, 3'(s), 12'(f), 16'(l), 16'(r), 13'($urandom),
          18'($urandom), 8'($urandom), 8'($urandom)};
    send_item(c);
  endtask

  task automatic send_define(input int s, input int len, input int rt);
    mix_cmd_t c;
    c = '{mvsm_pkg::OP_DEFINE, 3'(s), 12'($urandom), 16'($urandom), 16'($urandom),
          13'(len), 18'(rt), 8'($urandom), 8'($urandom)};
    send_item(c);
  endtask

  task automatic send_play(input int s, input int v, input int p);
    mix_cmd_t c;
    c = '{mvsm_pkg::OP_PLAY, 3'(s), 12'($urandom), 16'($urandom), 16'($urandom),
          13'($urandom), 18'($urandom), 8'(v), 8'(p)};
    send_item(c);
  endtask

  // A render must never read a frame that was never written, so any frame
  // that an active voice is about to read gets written first.
  task automatic send_render();
    mix_cmd_t c;
    logic [15:0] pos;
    bit found;
    do begin
      found = 0;
      for (int i = 0; i < voice_cnt && !found; i++) begin
        pos = voices[i].phase[31:16];
        if (pos < slot_len[voices[i].slot] && !pcm_written[voices[i].slot][pos]) begin
          found = 1;
          send_write(voices[i].slot, pos, $urandom, $urandom);
        end
      end
    end while (found);
    c = '{mvsm_pkg::OP_RENDER, 3'($urandom), 12'($urandom), 16'($urandom),
          16'($urandom), 13'($urandom), 18'($urandom), 8'($urandom), 8'($urandom)};
    send_item(c);
  endtask

  // Waits until every expected output has arrived, with the input idle.
  task automatic drain();
    drop_valid();
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_out_rate(input logic [16:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    rate_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic render_until_silent();
    while (voice_cnt != 0) send_render();
  endtask

  // With nothing playing a render is silent; an empty slot is accepted and
  // leaves at the next render without adding anything.
  task automatic test_silence_and_empty_slot();
    send_render();
    send_play(3, 255, 128);
    send_render();
    send_render();
  endtask

  // Full-scale samples at the ends of the store, hard left and hard right
  // pans, and enough loud voices to drive both sums into saturation.
  task automatic test_extremes();
    send_write(0, 0, -32768, 32767);
    send_write(0, 1, 32767, -32768);
    send_write(7, 4095, 32767, 32767);
    send_define(0, 2, 44100);
    send_play(0, 255, 0);
    send_play(0, 255, 255);
    send_play(0, 0, 128);
    send_play(0, 255, 128);
    send_play(0, 255, 1);
    send_play(0, 255, 254);
    send_render();
    send_render();
    // Oversized length saturates; the largest rate still gives a step below the saturation limit.
    send_define(7, 8191, 262143);
    send_play(7, 200, 77);
    render_until_silent();
  endtask

  // The seventeenth play finds the voice table full and is dropped.
  task automatic test_voice_table_full();
    send_define(1, 3, 22050);
    for (int i = 0; i <= mvsm_pkg::MAX_VOICES; i++) send_play(1, $urandom, $urandom);
    send_render();
    send_play(1, 255, 0);
    render_until_silent();
  endtask

  // A slot redefined while a voice plays it takes effect on that voice.
  task automatic test_redefine_while_playing();
    send_define(2, 6, 44100);
    send_play(2, 180, 60);
    send_render();
    send_define(2, 12, 11025);
    send_render();
    send_define(2, 0, 44100);
    send_render();
  endtask

  // Output rate at its extremes; steps already worked out keep their value.
  task automatic test_output_rates();
    logic [16:0] rates [6] = '{17'd8000, 17'd96000, 17'd0, 17'd131071, 17'd1, 17'd44100};
    foreach (rates[k]) begin
      set_out_rate(rates[k]);
      send_define(4, 5, $urandom_range(1, 192000));
      send_play(4, $urandom, $urandom);
      send_play(2, $urandom, $urandom);
      render_until_silent();
    end
  endtask

  // One random transaction, mostly well-formed playback traffic.
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_define($urandom, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(1, 24),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 262143)
                                              : $urandom_range(4000, 192000));
    end else if (pick < 35) begin
      send_play($urandom, ($urandom_range(0, 7) == 0) ? 255 : $urandom,
                ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom);
    end else if (pick < 80) begin
      send_render();
    end else begin
      send_write($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) random_item();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the block fills up and stalls its input.
  task automatic test_receiver_hold();
    long_hold = 1;
    for (int i = 0; i < 12; i++) random_item();
    while (long_hold) @(posedge clk);
  endtask

  initial begin
    rate_reg = mvsm_pkg::OUT_RATE_RESET;
    voice_cnt = 0;
    foreach (slot_len[s]) begin
      slot_len[s] = '0;
      slot_step[s] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_silence_and_empty_slot();
    test_extremes();
    test_voice_table_full();
    test_redefine_while_playing();
    test_output_rates();
    test_receiver_hold();
    test_random(600);
    // The sender pauses here until every output has come back.
    drain();
    set_out_rate(17'($urandom_range(8000, 96000)));
    test_random(700);
    quiet = 1;
    test_random(200);

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_mix.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
